[sv/pft_pkg.sv]
// shared types and constants for the polygon even-odd fill test unit
`timescale 1ns / 1ps

package pft_pkg;

	// default vertex store depth
	localparam int MAX_VERTICES_DEF = 64;

	// field widths
	localparam int GRID_W    = 6;
	localparam int PIXEL_W   = 11;
	localparam int CELL_W    = 6;
	localparam int SCALED_W  = GRID_W + CELL_W;
	localparam int DIFF_W    = SCALED_W + 1;
	localparam int PROD_W    = 2 * DIFF_W;
	localparam int NUM_W     = PROD_W + 1;
	localparam int CROSS_W   = 7;
	localparam int IN_DATA_W  = 40;
	localparam int IN_USER_W  = 2;
	localparam int OUT_DATA_W = 16;

	// input word kinds
	localparam logic OP_APPEND = 1'b0;
	localparam logic OP_QUERY  = 1'b1;

	// configuration register indexes
	localparam logic REG_CELL_WIDTH  = 1'b0;
	localparam logic REG_CELL_HEIGHT = 1'b1;

	// configuration reset values
	localparam logic [CELL_W-1:0] CELL_SIZE_RESET = 6'd20;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_DRAIN,
		ST_DONE
	} pft_state_t;

	// controller to datapath
	typedef struct packed {
		logic append;
		logic start_query;
		logic rd_en;
		logic load_result;
	} pft_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic vcount_zero;
		logic issue_last;
		logic pipe_busy;
		logic out_free;
	} pft_status_t;

endpackage

[sv/pft_ctrl.sv]
// controller state machine of the polygon even-odd fill test unit
`timescale 1ns / 1ps

module pft_ctrl
	import pft_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_op,
	output logic        in_ready,
	input  pft_status_t status,
	output pft_cmd_t    cmd
);

	pft_state_t state_q;
	pft_state_t state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid && in_op == OP_QUERY) begin
					state_d = status.vcount_zero ? ST_DONE : ST_WALK;
				end
			end
			ST_WALK: begin
				if (status.issue_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!status.pipe_busy) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (status.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// outputs
	always_comb begin
		in_ready        = 1'b0;
		cmd.append      = 1'b0;
		cmd.start_query = 1'b0;
		cmd.rd_en       = 1'b0;
		cmd.load_result = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready        = 1'b1;
				cmd.append      = in_valid && in_op == OP_APPEND;
				cmd.start_query = in_valid && in_op == OP_QUERY;
			end
			ST_WALK: begin
				cmd.rd_en = 1'b1;
			end
			ST_DRAIN: begin
			end
			ST_DONE: begin
				cmd.load_result = status.out_free;
			end
			default: begin
			end
		endcase
	end

	// a read is only issued while walking
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_en |-> !in_ready)
		else $error("vertex read issued while taking input words");

	// leaving the drain state needs an empty edge pipeline
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRAIN && state_d == ST_DONE) |-> !status.pipe_busy)
		else $error("drain finished with edges in flight");

	// the closing read is followed by the drain
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK && status.issue_last) |=> state_q == ST_DRAIN)
		else $error("walk did not end after the closing read");

endmodule

[sv/pft_datapath.sv]
// vertex store, edge crossing pipeline and result register
`timescale 1ns / 1ps

module pft_datapath
	import pft_pkg::*;
#(
	parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  pft_cmd_t              cmd,
	output pft_status_t           status,
	input  logic                  cfg_valid,
	input  logic                  cfg_index,
	input  logic [CELL_W-1:0]     cfg_data,
	input  logic                  in_start,
	input  logic [IN_DATA_W-1:0]  in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [OUT_DATA_W-1:0] out_data
);

	localparam int AW = $clog2(MAX_VERTICES);
	localparam int CW = $clog2(MAX_VERTICES + 1);

	// input word fields
	logic [GRID_W-1:0]  in_vx;
	logic [GRID_W-1:0]  in_vy;
	logic [PIXEL_W-1:0] in_px;
	logic [PIXEL_W-1:0] in_py;

	assign in_vx = in_data[GRID_W-1:0];
	assign in_vy = in_data[2*GRID_W-1:GRID_W];
	assign in_px = in_data[2*GRID_W+PIXEL_W-1:2*GRID_W];
	assign in_py = in_data[2*GRID_W+2*PIXEL_W-1:2*GRID_W+PIXEL_W];

	logic [CELL_W-1:0] cell_width_q;
	logic [CELL_W-1:0] cell_height_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_width_q  <= CELL_SIZE_RESET;
			cell_height_q <= CELL_SIZE_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_CELL_WIDTH:  cell_width_q  <= cfg_data;
				REG_CELL_HEIGHT: cell_height_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	logic [CW-1:0] vcount_q;
	logic          ovf_q;
	logic [CW-1:0] base_count;
	logic          has_room;

	assign base_count = in_start ? '0 : vcount_q;
	assign has_room   = base_count < CW'(MAX_VERTICES);

	// vertex count and sticky overflow
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q <= '0;
			ovf_q    <= 1'b0;
		end else if (cmd.append) begin
			if (has_room) begin
				vcount_q <= base_count + CW'(1);
				if (in_start) begin
					ovf_q <= 1'b0;
				end
			end else begin
				ovf_q <= 1'b1;
			end
		end
	end

	logic [AW-1:0] addr_q;
	logic          closing_q;
	logic [AW-1:0] rd_addr;
	logic          rd_first;
	logic          addr_last;

	assign rd_addr   = closing_q ? '0 : addr_q;
	assign rd_first  = !closing_q && addr_q == '0;
	assign addr_last = CW'(addr_q) + CW'(1) == vcount_q;

	// walk address: every stored vertex, then the first one again
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q    <= '0;
			closing_q <= 1'b0;
		end else if (cmd.start_query) begin
			addr_q    <= '0;
			closing_q <= 1'b0;
		end else if (cmd.rd_en && !closing_q) begin
			if (addr_last) begin
				closing_q <= 1'b1;
			end else begin
				addr_q <= addr_q + AW'(1);
			end
		end
	end

	logic [2*GRID_W-1:0] vmem [MAX_VERTICES];
	logic [GRID_W-1:0]   rd_x_s1;
	logic [GRID_W-1:0]   rd_y_s1;

	// vertex memory write
	always_ff @(posedge clk) begin
		if (cmd.append && has_room) begin
			vmem[base_count[AW-1:0]] <= {in_vy, in_vx};
		end
	end

	// vertex memory registered read
	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			{rd_y_s1, rd_x_s1} <= vmem[rd_addr];
		end
	end

	logic               v_s1, first_s1;
	logic               v_s2, first_s2;
	logic               v_s3, cnt_s3, dpos_s3;
	logic               v_s4, cnt_s4, dpos_s4;
	logic [SCALED_W-1:0] sx_s2, sy_s2;
	logic [SCALED_W-1:0] prev_x_q, prev_y_q;
	logic [PIXEL_W-1:0]  px_q, py_q;

	// pipeline valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= cmd.rd_en;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// query pixel
	always_ff @(posedge clk) begin
		if (cmd.start_query) begin
			px_q <= in_px;
			py_q <= in_py;
		end
	end

	// scale grid vertex to pixels
	always_ff @(posedge clk) begin
		first_s1 <= rd_first;
		first_s2 <= first_s1;
		sx_s2    <= SCALED_W'(rd_x_s1) * SCALED_W'(cell_width_q);
		sy_s2    <= SCALED_W'(rd_y_s1) * SCALED_W'(cell_height_q);
	end

	// previous vertex is the edge start
	always_ff @(posedge clk) begin
		if (v_s2) begin
			prev_x_q <= sx_s2;
			prev_y_q <= sy_s2;
		end
	end

	logic signed [DIFF_W-1:0] ax_e, ay_e, bx_e, by_e, px_e, py_e;
	logic signed [DIFF_W-1:0] apx_s3, dy_s3, pya_s3, dx_s3;
	logic                     straddle;

	assign ax_e = $signed({1'b0, prev_x_q});
	assign ay_e = $signed({1'b0, prev_y_q});
	assign bx_e = $signed({1'b0, sx_s2});
	assign by_e = $signed({1'b0, sy_s2});
	assign px_e = $signed({2'b00, px_q});
	assign py_e = $signed({2'b00, py_q});

	// edge straddles the pixel row with one end at or above it
	assign straddle = (ay_e <= py_e && by_e > py_e) || (ay_e > py_e && by_e <= py_e);

	// edge differences
	always_ff @(posedge clk) begin
		cnt_s3  <= !first_s2 && straddle;
		dpos_s3 <= by_e > ay_e;
		apx_s3  <= ax_e - px_e;
		dy_s3   <= by_e - ay_e;
		pya_s3  <= py_e - ay_e;
		dx_s3   <= bx_e - ax_e;
	end

	logic signed [PROD_W-1:0] p1_s4, p2_s4;

	// cross products
	always_ff @(posedge clk) begin
		cnt_s4  <= cnt_s3;
		dpos_s4 <= dpos_s3;
		p1_s4   <= PROD_W'(apx_s3) * PROD_W'(dy_s3);
		p2_s4   <= PROD_W'(pya_s3) * PROD_W'(dx_s3);
	end

	logic signed [NUM_W-1:0] num;
	logic                    hit;
	logic [CW-1:0]           count_q;

	assign num = NUM_W'(p1_s4) + NUM_W'(p2_s4);
	assign hit = dpos_s4 ? (num < NUM_W'(0)) : (num > NUM_W'(0));

	// crossing counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.start_query) begin
			count_q <= '0;
		end else if (v_s4 && cnt_s4 && hit) begin
			count_q <= count_q + CW'(1);
		end
	end

	logic [CROSS_W-1:0] cross_sat;

	assign cross_sat = (32'(count_q) > 32'd127) ? 7'd127 : CROSS_W'(count_q);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.load_result) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_result) begin
			out_data <= {7'd0, ovf_q, cross_sat, count_q[0]};
		end
	end

	// status to the controller
	assign status.vcount_zero = vcount_q == '0;
	assign status.issue_last  = closing_q;
	assign status.pipe_busy   = v_s1 || v_s2 || v_s3 || v_s4;
	assign status.out_free    = !out_valid || out_ready;

	// stored vertex count stays within the store
	assert property (@(posedge clk) disable iff (!arst_n)
		vcount_q <= CW'(MAX_VERTICES))
		else $error("vertex count beyond store depth");

	// a result is only loaded with all edges counted
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_result |-> !(v_s1 || v_s2 || v_s3 || v_s4))
		else $error("result loaded with edges in flight");

	// a loaded result shows up on the output
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_result |=> out_valid)
		else $error("loaded result not presented");

endmodule

[sv/polygon_even_odd_fill_test_unit.sv]
// top level of the polygon even-odd fill test unit
//
// Input words arrive on the s_axis channel. tuser[0] selects the kind:
// an append word stores one grid vertex (tuser[1] starts a new polygon and
// clears the store and the overflow flag), a query word names a pixel.
// Appends produce no output word; a query produces one word on m_axis with
// the inside bit, the crossing count and the overflow flag.
// Cell width and height are to be written on the cfg channel only while idle;
// the unit itself does not enforce this. A query with n stored vertices walks
// the vertex memory, reading one vertex per cycle, n reads plus one closing
// read of the first vertex; then a four-stage scale / difference / product /
// count pipeline drains, and the result is loaded into the output register.
// New words are taken only between queries; appends are still accepted while
// a result waits on m_axis, and a finished query holds until the output
// register is free.
// After reset the store is empty, the overflow flag is clear and both cell
// sizes are 20; no clearing pass is needed.
`timescale 1ns / 1ps

module polygon_even_odd_fill_test_unit
	import pft_pkg::*;
#(
	parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// vertex_x[5:0], vertex_y[11:6], pixel_x[22:12], pixel_y[33:23], zero fill
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	// op[0], start_polygon[1]
	input  logic [IN_USER_W-1:0]  s_axis_tuser,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// inside_res[0], crossings[7:1], overflowed[8], zero fill
	output logic [OUT_DATA_W-1:0] m_axis_tdata,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic                  cfg_index,
	input  logic [CELL_W-1:0]     cfg_data
);

	pft_cmd_t    cmd;
	pft_status_t status;

	// configuration writes are always taken
	assign cfg_ready = 1'b1;

	pft_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_op    (s_axis_tuser[0]),
		.in_ready (s_axis_tready),
		.status   (status),
		.cmd      (cmd)
	);

	pft_datapath #(
		.MAX_VERTICES (MAX_VERTICES)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_start  (s_axis_tuser[1]),
		.in_data   (s_axis_tdata),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata)
	);

endmodule
